### hw/rtl/nds_pkg.sv
package nds_pkg;

    localparam int SIDE_W = 13;
    localparam int POS_W  = 12;
    localparam int PROD_W = 2 * SIDE_W;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 5;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 88;
    localparam logic [SIDE_W-1:0] MAX_SIDE = 13'd4096;
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(PROD_W - 1);
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LIMIT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_LIMIT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_BYTE_ORDER   = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BAD,
        ST_RATIO,
        ST_MUL_A,
        ST_CMP,
        ST_MUL_W,
        ST_DIV_W_GO,
        ST_DIV_W,
        ST_MUL_H,
        ST_DIV_H_GO,
        ST_DIV_H,
        ST_SELECT,
        ST_EMIT,
        ST_DIV_C,
        ST_ADVANCE,
        ST_DIV_R,
        ST_ROW_END
    } state_t;

    typedef enum logic [1:0] {
        MUL_MH_Q,
        MUL_P_H,
        MUL_W_P,
        MUL_H_P
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_SIZE,
        DIV_COL,
        DIV_ROW
    } div_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     set_ratio;
        logic     mul_load;
        logic     cmp_ratio;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     set_width;
        logic     set_height;
        logic     emit_bad;
        logic     emit_pix;
        logic     col_update;
        logic     col_step;
        logic     row_update;
        logic     row_end;
    } cmd_t;

    typedef struct packed {
        logic sizes_ready;
        logic zero_size;
        logic sel_hit;
        logic row_hit;
        logic row_last_col;
        logic div_done;
        logic div_busy;
        logic out_busy;
    } status_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : v;
    endfunction

endpackage

### hw/rtl/nds_div.sv
module nds_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nds_pkg::PROD_W-1:0]  dividend,
    input  logic [nds_pkg::SIDE_W-1:0]  divisor,
    output logic [nds_pkg::PROD_W-1:0]  quot,
    output logic [nds_pkg::SIDE_W-1:0]  rem,
    output logic                        busy,
    output logic                        done
);
    import nds_pkg::*;

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [SIDE_W-1:0] rem_reg, rem_next;
    logic [SIDE_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SIDE_W:0]   trial;
    logic [SIDE_W:0]   diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            rem_next = ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### hw/rtl/nds_datapath.sv
module nds_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  nds_pkg::cmd_t               cmd,
    output nds_pkg::status_t            status,
    input  logic [nds_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nds_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nds_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata
);
    import nds_pkg::*;

    logic [SIDE_W-1:0] src_w_reg, src_h_reg, lim_w_reg, lim_h_reg;
    logic [1:0]        order_reg;
    logic [IN_W-1:0]   pix_reg;
    logic [SIDE_W-1:0] w, h, mw, mh;
    logic [2:0]        cfg_idx;
    logic              cfg_wr, restart;

    logic [SIDE_W-1:0] in_col_reg, in_row_reg, nct_reg, nrt_reg;
    logic [SIDE_W-1:0] crem_reg, rrem_reg, ec_reg, er_reg, sw_reg, sh_reg;
    logic              ready_reg;
    logic [SIDE_W-1:0] p_reg, q_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [SIDE_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_out;
    logic [PROD_W-1:0] div_dvd;
    logic [SIDE_W-1:0] div_dvs;
    logic [PROD_W-1:0] div_q;
    logic [SIDE_W-1:0] div_r, div_q13;
    logic              div_busy, div_done;
    logic [SIDE_W:0]   col_inc, row_inc;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg, out_bad_reg;
    logic [7:0]        red, green, blue, alpha;
    logic              last_pix;

    assign w  = clamp_side(src_w_reg);
    assign h  = clamp_side(src_h_reg);
    assign mw = clamp_side(lim_w_reg);
    assign mh = clamp_side(lim_h_reg);

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && (cfg_idx <= REG_BYTE_ORDER);

    always_comb
    begin
        case (cfg_idx)
            REG_SRC_WIDTH:    prdata = {19'd0, src_w_reg};
            REG_SRC_HEIGHT:   prdata = {19'd0, src_h_reg};
            REG_LIMIT_WIDTH:  prdata = {19'd0, lim_w_reg};
            REG_LIMIT_HEIGHT: prdata = {19'd0, lim_h_reg};
            REG_BYTE_ORDER:   prdata = {30'd0, order_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            lim_w_reg <= MAX_SIDE;
            lim_h_reg <= MAX_SIDE;
            order_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SRC_WIDTH:    src_w_reg <= pwdata[SIDE_W-1:0];
                REG_SRC_HEIGHT:   src_h_reg <= pwdata[SIDE_W-1:0];
                REG_LIMIT_WIDTH:  lim_w_reg <= pwdata[SIDE_W-1:0];
                REG_LIMIT_HEIGHT: lim_h_reg <= pwdata[SIDE_W-1:0];
                REG_BYTE_ORDER:   order_reg <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_MH_Q: begin mul_a = mh; mul_b = q_reg; end
            MUL_P_H:  begin mul_a = p_reg; mul_b = h; end
            MUL_W_P:  begin mul_a = w; mul_b = p_reg; end
            MUL_H_P:  begin mul_a = h; mul_b = p_reg; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        mul_out = mul_a * mul_b;
    end

    assign col_inc = {1'b0, crem_reg} + {1'b0, w};
    assign row_inc = {1'b0, rrem_reg} + {1'b0, h};

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SIZE: begin div_dvd = prod_reg; div_dvs = q_reg; end
            DIV_COL:  begin div_dvd = PROD_W'(col_inc); div_dvs = sw_reg; end
            DIV_ROW:  begin div_dvd = PROD_W'(row_inc); div_dvs = sh_reg; end
            default:  begin div_dvd = '0; div_dvs = '0; end
        endcase
    end

    nds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quot     (div_q),
        .rem      (div_r),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign div_q13 = div_q[SIDE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
            pix_reg <= s_tdata;
        if (cmd.set_ratio)
        begin
            p_reg <= (mw < w) ? mw : SIDE_W'(1);
            q_reg <= (mw < w) ? w : SIDE_W'(1);
        end
        else if (cmd.cmp_ratio && (prod_reg < mul_out))
        begin
            p_reg <= mh;
            q_reg <= h;
        end
        if (cmd.mul_load)
            prod_reg <= mul_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            nct_reg    <= '0;
            nrt_reg    <= '0;
            crem_reg   <= '0;
            rrem_reg   <= '0;
            ec_reg     <= '0;
            er_reg     <= '0;
            sw_reg     <= '0;
            sh_reg     <= '0;
            ready_reg  <= 1'b0;
        end
        else if (restart ||
                 (cmd.row_end && ({1'b0, in_row_reg} + 1'b1 >= {1'b0, h})))
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            nct_reg    <= '0;
            nrt_reg    <= '0;
            crem_reg   <= '0;
            rrem_reg   <= '0;
            ec_reg     <= '0;
            er_reg     <= '0;
            sw_reg     <= '0;
            sh_reg     <= '0;
            ready_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.set_width)
                sw_reg <= (div_q == '0) ? SIDE_W'(1) : div_q13;
            if (cmd.set_height)
            begin
                sh_reg     <= (div_q == '0) ? SIDE_W'(1) : div_q13;
                ready_reg  <= 1'b1;
                in_col_reg <= '0;
                in_row_reg <= '0;
                nct_reg    <= '0;
                nrt_reg    <= '0;
                crem_reg   <= '0;
                rrem_reg   <= '0;
                ec_reg     <= '0;
                er_reg     <= '0;
            end
            if (cmd.col_update)
            begin
                nct_reg  <= nct_reg + div_q13;
                crem_reg <= div_r;
                ec_reg   <= ec_reg + 1'b1;
            end
            if (cmd.col_step)
                in_col_reg <= in_col_reg + 1'b1;
            if (cmd.row_update)
            begin
                nrt_reg  <= nrt_reg + div_q13;
                rrem_reg <= div_r;
                er_reg   <= er_reg + 1'b1;
            end
            if (cmd.row_end)
            begin
                in_col_reg <= '0;
                ec_reg     <= '0;
                nct_reg    <= '0;
                crem_reg   <= '0;
                in_row_reg <= in_row_reg + 1'b1;
            end
        end
    end

    // byte swizzle to RGBA
    assign red      = order_reg[1] ? pix_reg[23:16] : pix_reg[7:0];
    assign green    = pix_reg[15:8];
    assign blue     = order_reg[1] ? pix_reg[7:0] : pix_reg[23:16];
    assign alpha    = order_reg[0] ? ALPHA_OPAQUE : pix_reg[31:24];
    assign last_pix = (ec_reg + 1'b1 == sw_reg) && (er_reg + 1'b1 == sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_pix || cmd.emit_bad)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pix)
        begin
            out_data_reg <= {6'd0, sh_reg, sw_reg, er_reg[POS_W-1:0], ec_reg[POS_W-1:0],
                             alpha, blue, green, red};
            out_last_reg <= last_pix;
            out_bad_reg  <= 1'b0;
        end
        else if (cmd.emit_bad)
        begin
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
            out_bad_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

    always_comb
    begin
        status.sizes_ready  = ready_reg;
        status.zero_size    = (w == '0) || (h == '0) || (mw == '0) || (mh == '0);
        status.sel_hit      = (in_row_reg == nrt_reg) && (in_col_reg == nct_reg) &&
                              (er_reg < sh_reg) && (ec_reg < sw_reg);
        status.row_hit      = (in_row_reg == nrt_reg) && (er_reg < sh_reg);
        status.row_last_col = ({1'b0, in_col_reg} + 1'b1) >= {1'b0, w};
        status.div_done     = div_done;
        status.div_busy     = div_busy;
        status.out_busy     = out_valid_reg && !m_tready;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pix || cmd.emit_bad) |-> !(out_valid_reg && !m_tready))
        else $error("result loaded over a stalled beat");
    a_ready_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (sw_reg != '0) && (sh_reg != '0))
        else $error("output size zero while sizes are ready");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> ec_reg <= sw_reg)
        else $error("output column ran past the output width");
`endif

endmodule

### hw/rtl/nds_ctrl.sv
module nds_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  nds_pkg::status_t  status,
    output nds_pkg::cmd_t     cmd
);
    import nds_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_MH_Q;
        cmd.div_sel = DIV_SIZE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.sizes_ready)
                    state_next = ST_SELECT;
                else if (status.zero_size)
                    state_next = ST_BAD;
                else
                    state_next = ST_RATIO;
            end
            ST_BAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RATIO:
            begin
                cmd.set_ratio = 1'b1;
                state_next    = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_sel  = MUL_MH_Q;
                cmd.mul_load = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.mul_sel   = MUL_P_H;
                cmd.cmp_ratio = 1'b1;
                state_next    = ST_MUL_W;
            end
            ST_MUL_W:
            begin
                cmd.mul_sel  = MUL_W_P;
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV_W_GO;
            end
            ST_DIV_W_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                if (status.div_done)
                begin
                    cmd.set_width = 1'b1;
                    state_next    = ST_MUL_H;
                end
            end
            ST_MUL_H:
            begin
                cmd.mul_sel  = MUL_H_P;
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV_H_GO;
            end
            ST_DIV_H_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_H;
            end
            ST_DIV_H:
            begin
                if (status.div_done)
                begin
                    cmd.set_height = 1'b1;
                    state_next     = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                state_next = status.sel_hit ? ST_EMIT : ST_ADVANCE;
            end
            ST_EMIT:
            begin
                // hold until the output register frees up
                if (!status.out_busy)
                begin
                    cmd.emit_pix  = 1'b1;
                    cmd.div_sel   = DIV_COL;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_C;
                end
            end
            ST_DIV_C:
            begin
                cmd.div_sel = DIV_COL;
                if (status.div_done)
                begin
                    cmd.col_update = 1'b1;
                    state_next     = ST_ADVANCE;
                end
            end
            ST_ADVANCE:
            begin
                if (!status.row_last_col)
                begin
                    cmd.col_step = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.row_hit)
                begin
                    cmd.div_sel   = DIV_ROW;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_R;
                end
                else
                    state_next = ST_ROW_END;
            end
            ST_DIV_R:
            begin
                cmd.div_sel = DIV_ROW;
                if (status.div_done)
                begin
                    cmd.row_update = 1'b1;
                    state_next     = ST_ROW_END;
                end
            end
            ST_ROW_END:
            begin
                cmd.row_end = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_selected: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> $past(status.sel_hit))
        else $error("emit entered without a selected pixel");
    a_bad_unsized: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_bad |-> !status.sizes_ready)
        else $error("bad result while sizes are ready");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pix || cmd.emit_bad) |=> (state_reg != ST_EMIT) && (state_reg != ST_BAD))
        else $error("second result for one pixel");
`endif

endmodule

### hw/rtl/nearest_downscale_rgba_swizzle.sv
// Nearest-neighbor frame downscaler with RGBA byte reordering.
// Slave stream: one source pixel per beat in raster order, four bytes in
// memory order. Master stream: selected pixels in RGBA with their output
// position and the output frame size; tlast marks the final pixel of the
// frame, tuser flags a zero source or limit size.
// Configuration goes through the APB port at byte addresses 0x0..0x10:
// source width, source height, width limit, height limit, byte order.
// A write to one of these registers restarts the frame; write only while the block is idle.
// Each pixel steps through check, select and advance, plus a row-end
// step at row end. A selected pixel adds an emit step and the remainder
// step in the shared 26-bit shift-subtract divider; a row step at row end
// uses the divider again. The first pixel of a frame adds the ratio,
// multiply and compare steps and two divider runs to size the output.
// Reset clears the frame position and restores the register defaults.
// While the receiver stalls, the result waits in the output register; the
// next pixel is still taken and is held before its own result is loaded.
module nearest_downscale_rgba_swizzle
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // byte_zero, byte_one, byte_two, byte_three
    input  logic [nds_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // red, green, blue, alpha, out_col, out_row, frame_width, frame_height
    output logic [nds_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    // bad_config
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nds_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import nds_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    nds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nds_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

### bench/nearest_downscale_rgba_swizzle_tb.sv
`timescale 1ns / 1ps

module nearest_downscale_rgba_swizzle_tb;
    import nds_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam int SETTLE_CYCLES = 300;
    localparam int PIXEL_BUDGET  = 1850;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] col;
        logic [11:0] row;
        logic [12:0] fw;
        logic [12:0] fh;
        logic        last;
        logic        bad;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    nearest_downscale_rgba_swizzle DUT (.*);

    // register mirror and scaler state
    int unsigned src_w, src_h, lim_w, lim_h, order;
    int unsigned in_col, in_row, tgt_col, tgt_row, rem_col, rem_row;
    int unsigned emit_col, emit_row, out_w, out_h;
    bit          sized;

    pixel_t pixels_due[$];
    int     errors;
    int     pixels_sent;
    bit     tx_busy_free;
    bit     rx_busy_free;
    int     rx_wait;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned sat_side(int unsigned v);
        return (v > 4096) ? 4096 : v;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; tgt_col = 0; tgt_row = 0;
        rem_col = 0; rem_row = 0; emit_col = 0; emit_row = 0;
        out_w = 0; out_h = 0; sized = 1'b0;
    endfunction

    function automatic void predict_pixel(logic [IN_W-1:0] d);
        int unsigned w, h, mw, mh, acc;
        longint unsigned p, q, ow, oh;
        logic [7:0] b0, b1, b2, b3;
        pixel_t r;
        w = sat_side(src_w); h = sat_side(src_h);
        mw = sat_side(lim_w); mh = sat_side(lim_h);
        b0 = d[7:0]; b1 = d[15:8]; b2 = d[23:16]; b3 = d[31:24];
        r = '0;
        if (!sized)
        begin
            if (w == 0 || h == 0 || mw == 0 || mh == 0)
            begin
                r.bad = 1'b1;
                pixels_due.push_back(r);
                return;
            end
            p = 1; q = 1;
            if (longint'(mw) * q < p * w)
            begin
                p = mw; q = w;
            end
            if (longint'(mh) * q < p * h)
            begin
                p = mh; q = h;
            end
            ow = w * p / q;
            oh = h * p / q;
            out_w = (ow < 1) ? 1 : int'(ow);
            out_h = (oh < 1) ? 1 : int'(oh);
            in_col = 0; in_row = 0; emit_col = 0; emit_row = 0;
            tgt_col = 0; tgt_row = 0; rem_col = 0; rem_row = 0;
            sized = 1'b1;
        end
        if (in_row == tgt_row && in_col == tgt_col && emit_row < out_h && emit_col < out_w)
        begin
            r.red   = order[1] ? b2 : b0;
            r.green = b1;
            r.blue  = order[1] ? b0 : b2;
            r.alpha = order[0] ? ALPHA_OPAQUE : b3;
            r.col   = emit_col[11:0];
            r.row   = emit_row[11:0];
            r.fw    = out_w[12:0];
            r.fh    = out_h[12:0];
            r.last  = (emit_col + 1 == out_w) && (emit_row + 1 == out_h);
            pixels_due.push_back(r);
            acc = rem_col + w;
            tgt_col += acc / out_w;
            rem_col = acc % out_w;
            emit_col++;
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            if (in_row == tgt_row && emit_row < out_h)
            begin
                acc = rem_row + h;
                tgt_row += acc / out_h;
                rem_row = acc % out_h;
                emit_row++;
            end
            emit_col = 0; tgt_col = 0; rem_col = 0;
            in_row++;
            if (in_row >= h)
                restart_frame();
        end
    endfunction

    // valid stays high across back-to-back beats; drop it only on a gap
    task automatic send_pixel(logic [IN_W-1:0] d);
        int gap;
        gap = tx_busy_free ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        predict_pixel(d);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:    src_w = val & 32'h1FFF;
            REG_SRC_HEIGHT:   src_h = val & 32'h1FFF;
            REG_LIMIT_WIDTH:  lim_w = val & 32'h1FFF;
            REG_LIMIT_HEIGHT: lim_h = val & 32'h1FFF;
            REG_BYTE_ORDER:   order = val & 32'h3;
            default:          return;
        endcase
        restart_frame();
    endtask

    task automatic set_frame(int unsigned sw, int unsigned sh, int unsigned lw,
                             int unsigned lh, int unsigned bo);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_LIMIT_WIDTH, lw);
        write_reg(REG_LIMIT_HEIGHT, lh);
        write_reg(REG_BYTE_ORDER, bo);
    endtask

    task automatic send_burst(int n);
        repeat (n) send_pixel($urandom);
    endtask

    // receiver: draw a stall after every beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wait  = 0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_wait = rx_busy_free ? 0 : $urandom_range(0, 6);
            else if (rx_wait > 0)
                rx_wait--;
            m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        pixel_t e, a;
        if (rst_n && m_tvalid && m_tready)
        begin
            a.red   = m_tdata[7:0];
            a.green = m_tdata[15:8];
            a.blue  = m_tdata[23:16];
            a.alpha = m_tdata[31:24];
            a.col   = m_tdata[43:32];
            a.row   = m_tdata[55:44];
            a.fw    = m_tdata[68:56];
            a.fh    = m_tdata[81:69];
            a.last  = m_tlast;
            a.bad   = m_tuser;
            if (pixels_due.size() == 0)
            begin
                $display("%0t: unexpected beat %h last %b bad %b", $time, m_tdata, m_tlast,
                         m_tuser);
                errors++;
            end
            else
            begin
                e = pixels_due.pop_front();
                if (a != e)
                begin
                    $display({"%0t: expected rgba %h %h %h %h col %0d row %0d",
                              " size %0dx%0d last %b bad %b"},
                             $time, e.red, e.green, e.blue, e.alpha, e.col, e.row, e.fw, e.fh,
                             e.last, e.bad);
                    $display({"%0t: actual   rgba %h %h %h %h col %0d row %0d",
                              " size %0dx%0d last %b bad %b"},
                             $time, a.red, a.green, a.blue, a.alpha, a.col, a.row, a.fw, a.fh,
                             a.last, a.bad);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_defaults();
        // source size is zero after reset
        send_burst(2);
        wait_idle();
    endtask

    task automatic test_byte_orders();
        int bo;
        set_frame(4, 3, 4096, 4096, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_burst(10);
        wait_idle();
        for (bo = 1; bo < 4; bo++)
        begin
            set_frame(2, 2, 1, 1, bo);
            send_burst(4);
            wait_idle();
        end
    endtask

    task automatic test_zero_and_saturation();
        set_frame(3, 3, 0, 4096, 0);
        send_burst(1);
        wait_idle();
        set_frame(8191, 8191, 8191, 8191, 2);
        send_pixel(32'hA5C3_5A3C);
        send_burst(5);
        wait_idle();
        // write past the register list, then finish the frame
        set_frame(5, 2, 2, 4096, 1);
        write_reg(REG_SPARE, 32'h1FFF);
        send_burst(10);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int unsigned sw, sh, lw, lh, n;
        while (pixels_sent < PIXEL_BUDGET)
        begin
            tx_busy_free = ($urandom_range(0, 3) == 0);
            rx_busy_free = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    sw = $urandom_range(0, 8191); sh = $urandom_range(0, 8191);
                    lw = $urandom_range(0, 8191); lh = $urandom_range(0, 8191);
                    n  = $urandom_range(1, 12);
                end
                1:
                begin
                    sw = $urandom_range(0, 6); sh = $urandom_range(0, 6);
                    lw = $urandom_range(0, 6); lh = $urandom_range(0, 6);
                    n  = $urandom_range(1, 20);
                end
                default:
                begin
                    sw = $urandom_range(1, 12); sh = $urandom_range(1, 10);
                    lw = $urandom_range(1, 14); lh = $urandom_range(1, 12);
                    n  = sw * sh * $urandom_range(1, 3);
                    // cut the last frame short now and then
                    if ($urandom_range(0, 4) == 0)
                        n = n - $urandom_range(0, sw * sh - 1);
                end
            endcase
            set_frame(sw, sh, lw, lh, $urandom_range(0, 3));
            send_burst(n);
            wait_idle();
        end
        tx_busy_free = 1'b0;
        rx_busy_free = 1'b0;
    endtask

    initial
    begin
        errors       = 0;
        pixels_sent  = 0;
        tx_busy_free = 1'b0;
        rx_busy_free = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        src_w = 0; src_h = 0; lim_w = 4096; lim_h = 4096; order = 0;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_byte_orders();
        test_zero_and_saturation();
        test_random_frames();
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
